// File: design/tv_divergence_stencil_top_macros.svh
// ----------------------------------------------------------------------------
// tv divergence stencil assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef TV_DIVERGENCE_STENCIL_TOP_MACROS_SVH
`define TV_DIVERGENCE_STENCIL_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TVD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define TVD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define TVD_ASSERT(lbl, expr, msg)
`define TVD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: design/tvd_pkg.sv
// ----------------------------------------------------------------------------
// tvd_pkg
// shared widths, types and codes of the tv divergence stencil
// ----------------------------------------------------------------------------
package tvd_pkg;

  localparam int PIX_W       = 16;
  localparam int MAX_WIDTH   = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 16;
  localparam int WCFG_W      = 13;
  localparam int EPS_W       = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_W       = 32;
  localparam int DIFF_W      = PIX_W + 1;
  localparam int NUM_W       = PIX_W + 3;
  localparam int MAG_W       = PIX_W + 2;
  localparam int SUM_W       = 2 * PIX_W + 2;
  localparam int SQRT_SHIFT  = 62 - 2 * PIX_W;
  localparam int RAD_W       = SUM_W + SQRT_SHIFT;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int SREM_W      = ROOT_W + 3;
  localparam int DIV_SHIFT   = 47 - PIX_W;
  localparam int DVD_W       = MAG_W + DIV_SHIFT + 1;
  localparam int ITER_W      = 6;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
  localparam int SAT_EXP     = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_EPSILON      = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RD2,
    F_CALC,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ,
    B_SQRT,
    B_PREP,
    B_DIV,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic [WCFG_W-1:0] image_width;
    logic [ROW_W-1:0]  image_height;
    logic [EPS_W-1:0]  epsilon;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
    logic             has_l;
    logic             has_r;
    logic             has_u;
    logic             has_d;
    logic             frame_end;
  } job_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } fifo_status_t;

endpackage

// File: design/tvd_pixel_if.sv
// ----------------------------------------------------------------------------
// tvd_pixel_if
// input stream channel, one pixel per transaction
// ----------------------------------------------------------------------------
interface tvd_pixel_if import tvd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

// File: design/tvd_result_if.sv
// ----------------------------------------------------------------------------
// tvd_result_if
// result stream channel, one divergence value per transaction
// ----------------------------------------------------------------------------
interface tvd_result_if import tvd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] divergence;
  logic                    frame_end;

  modport source (output valid, output divergence, output frame_end, input ready);
  modport sink (input valid, input divergence, input frame_end, output ready);
endinterface

// File: design/tvd_front.sv
// ----------------------------------------------------------------------------
// tvd_front
// raster position tracking, line stores and stencil gathering
// ----------------------------------------------------------------------------
module tvd_front import tvd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  tvd_pixel_if.sink  in_ch,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  front_state_e state_q, state_d;

  logic [COL_W-1:0]  column_count_q, c_q, c_cur;
  logic [COL_W-1:0]  cen_a0, cen_a1, ab_a0, ab_a1;
  logic [ROW_W-1:0]  row_count_q, r_q, r_cur, h_eff;
  logic [WCFG_W-1:0] w_eff;
  logic              last_col, last_row, last_col_q, last_row_q;
  logic              accept;
  logic [PIX_W-1:0]  prev_q, p_q, m_q, mr_q, a_q, a1_q;
  logic [PIX_W-1:0]  cen_rd0_q, cen_rd1_q, ab_rd0_q, ab_rd1_q;
  logic [PIX_W-1:0]  cen_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  ab_mem [MAX_WIDTH];
  job_t              job_q [3];
  job_t              jobs [3];
  logic [2:0]        en_q, en_d;
  logic [1:0]        sel;

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      w_eff = WCFG_W'(1);
    end else if (cfg_i.image_width > WCFG_W'(MAX_WIDTH)) begin
      w_eff = WCFG_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg_i.image_width;
    end
    h_eff = (cfg_i.image_height == '0) ? ROW_W'(1) : cfg_i.image_height;
    c_cur = (WCFG_W'(column_count_q) < w_eff) ? column_count_q : COL_W'(w_eff - WCFG_W'(1));
    r_cur = (row_count_q < h_eff) ? row_count_q : ROW_W'(h_eff - ROW_W'(1));
    last_col = (WCFG_W'(c_cur) + WCFG_W'(1) == w_eff);
    last_row = ({1'b0, r_cur} + (ROW_W+1)'(1) == {1'b0, h_eff});
  end

  // stencil operands for the up to three results of this pixel
  always_comb begin
    jobs[0] = '{left: (c_q != '0) ? prev_q : m_q, centre: m_q,
                right: last_col_q ? m_q : mr_q, up: (r_q[ROW_W-1:1] != '0) ? a_q : m_q,
                down: p_q, has_l: (c_q != '0), has_r: !last_col_q,
                has_u: (r_q[ROW_W-1:1] != '0), has_d: 1'b1, frame_end: 1'b0};
    jobs[1] = '{left: (c_q[COL_W-1:1] != '0) ? cen_rd1_q : cen_rd0_q, centre: cen_rd0_q,
                right: p_q, up: (r_q != '0) ? a1_q : cen_rd0_q, down: cen_rd0_q,
                has_l: (c_q[COL_W-1:1] != '0), has_r: 1'b1, has_u: (r_q != '0),
                has_d: 1'b0, frame_end: 1'b0};
    jobs[2] = '{left: (c_q != '0) ? cen_rd0_q : p_q, centre: p_q, right: p_q,
                up: (r_q != '0) ? m_q : p_q, down: p_q, has_l: (c_q != '0), has_r: 1'b0,
                has_u: (r_q != '0), has_d: 1'b0, frame_end: 1'b1};
    en_d = {last_row_q && last_col_q, last_row_q && (c_q != '0), r_q != '0};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (accept) state_d = F_RD2;
      F_RD2:  state_d = F_CALC;
      F_CALC: state_d = F_PUSH;
      F_PUSH: if (en_q == '0) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_q == F_IDLE);
    if (en_q[0]) begin
      sel = 2'd0;
    end else if (en_q[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
    push_o = (state_q == F_PUSH) && (en_q != '0) && !full_i;
    job_o  = job_q[sel];
    cen_a0 = (state_q == F_IDLE) ? c_cur : c_q - COL_W'(1);
    cen_a1 = (state_q == F_IDLE) ? c_cur + COL_W'(1) : c_q - COL_W'(2);
    ab_a0  = c_cur;
    ab_a1  = c_cur - COL_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= F_IDLE;
      column_count_q <= '0;
      row_count_q    <= '0;
      prev_q         <= '0;
      en_q           <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_CALC) begin
        en_q   <= en_d;
        prev_q <= m_q;
        if (last_col_q) begin
          column_count_q <= '0;
          row_count_q    <= last_row_q ? '0 : r_q + ROW_W'(1);
        end else begin
          column_count_q <= c_q + COL_W'(1);
          row_count_q    <= r_q;
        end
      end else if (push_o) begin
        en_q[sel] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q        <= in_ch.pixel;
      c_q        <= c_cur;
      r_q        <= r_cur;
      last_col_q <= last_col;
      last_row_q <= last_row;
    end
    if (state_q == F_RD2) begin
      m_q  <= cen_rd0_q;
      mr_q <= cen_rd1_q;
      a_q  <= ab_rd0_q;
      a1_q <= ab_rd1_q;
    end
    if (state_q == F_CALC) begin
      job_q <= jobs;
    end
  end

  always_ff @(posedge clk_i) begin
    cen_rd0_q <= cen_mem[cen_a0];
    cen_rd1_q <= cen_mem[cen_a1];
    ab_rd0_q  <= ab_mem[ab_a0];
    ab_rd1_q  <= ab_mem[ab_a1];
    if (state_q == F_CALC) begin
      cen_mem[c_q] <= p_q;
      ab_mem[c_q]  <= m_q;
    end
  end

endmodule

// File: design/tvd_fifo.sv
// ----------------------------------------------------------------------------
// tvd_fifo
// short job queue between the front and the back engine
// ----------------------------------------------------------------------------
module tvd_fifo import tvd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  job_t         data_i,
  input  logic         pop_i,
  output job_t         data_o,
  output fifo_status_t status_o
);

  job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_CW-1:0] count_q;

  assign data_o          = mem_q[rd_q];
  assign status_o.full   = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign status_o.empty  = (count_q == '0);
  assign status_o.count  = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + FIFO_AW'(1);
      if (pop_i) rd_q <= rd_q + FIFO_AW'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + FIFO_CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// File: design/tvd_back.sv
// ----------------------------------------------------------------------------
// tvd_back
// divergence engine: shared squarer, bit-serial square root and divider
// ----------------------------------------------------------------------------
module tvd_back import tvd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  job_t          job_i,
  input  logic          empty_i,
  output logic          pop_o,
  tvd_result_if.source  out_ch
);

  back_state_e state_q, state_d;

  logic signed [DIFF_W-1:0] fx, bx, fy, by;
  logic signed [NUM_W-1:0]  num, num_q;
  logic [PIX_W-1:0]         fxm, fym, fxm_q, fym_q, sq_op;
  logic [MAG_W-1:0]         mag;
  logic [2*PIX_W-1:0]       prod;
  logic [SUM_W-1:0]         acc_q, acc_d;
  logic [1:0]               sq_cnt_q;
  logic [RAD_W-1:0]         rad_q;
  logic [SREM_W-1:0]        srem_q, srem_sh, trial;
  logic [ROOT_W-1:0]        root_q;
  logic [ITER_W-1:0]        iter_q;
  logic [ROOT_W-1:0]        drem_q;
  logic [ROOT_W:0]          drem_sh;
  logic                     ge;
  logic [DVD_W-1:0]         dq_q;
  logic                     fe_q, load, out_valid_q;
  logic [OUT_W-1:0]         sat, res, div_q;

  always_comb begin
    fx  = job_i.has_r ? $signed({1'b0, job_i.right}) - $signed({1'b0, job_i.centre}) : '0;
    bx  = job_i.has_l ? $signed({1'b0, job_i.centre}) - $signed({1'b0, job_i.left}) : '0;
    fy  = job_i.has_d ? $signed({1'b0, job_i.down}) - $signed({1'b0, job_i.centre}) : '0;
    by  = job_i.has_u ? $signed({1'b0, job_i.centre}) - $signed({1'b0, job_i.up}) : '0;
    num = NUM_W'(fx) - NUM_W'(bx) + NUM_W'(fy) - NUM_W'(by);
    fxm = fx[DIFF_W-1] ? PIX_W'(-fx) : PIX_W'(fx);
    fym = fy[DIFF_W-1] ? PIX_W'(-fy) : PIX_W'(fy);
    mag = num_q[NUM_W-1] ? MAG_W'(-num_q) : MAG_W'(num_q);
  end

  always_comb begin
    case (sq_cnt_q)
      2'd0:    sq_op = fxm_q;
      2'd1:    sq_op = fym_q;
      default: sq_op = cfg_i.epsilon;
    endcase
    prod  = sq_op * sq_op;
    acc_d = ((sq_cnt_q == 2'd0) ? '0 : acc_q) + SUM_W'(prod);
  end

  always_comb begin
    srem_sh = {srem_q[SREM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
    trial   = {1'b0, root_q, 2'b01};
    drem_sh = {drem_q, dq_q[DVD_W-1]};
    ge      = (drem_sh >= {1'b0, root_q});
  end

  always_comb begin
    div_q = OUT_W'(dq_q);
    if (num_q[NUM_W-1]) begin
      sat = (dq_q > DVD_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : div_q;
      res = 32'd0 - sat;
    end else begin
      sat = (dq_q > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q;
      res = sat;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!empty_i) state_d = B_SQ;
      B_SQ:   if (sq_cnt_q == 2'd2) state_d = B_SQRT;
      B_SQRT: if (iter_q == ITER_W'(ROOT_W - 1)) state_d = B_PREP;
      B_PREP: state_d = (root_q == '0) ? B_OUT : B_DIV;
      B_DIV:  if (iter_q == ITER_W'(DVD_W - 1)) state_d = B_OUT;
      B_OUT:  if (load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o = (state_q == B_IDLE) && !empty_i;
    load  = (state_q == B_OUT) && (!out_valid_q || out_ch.ready);
    out_ch.valid = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        num_q    <= num;
        fxm_q    <= fxm;
        fym_q    <= fym;
        fe_q     <= job_i.frame_end;
        sq_cnt_q <= '0;
      end
      B_SQ: begin
        acc_q    <= acc_d;
        sq_cnt_q <= sq_cnt_q + 2'd1;
        rad_q    <= {acc_d, {SQRT_SHIFT{1'b0}}};
        srem_q   <= '0;
        root_q   <= '0;
        iter_q   <= '0;
      end
      B_SQRT: begin
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        iter_q <= iter_q + ITER_W'(1);
        if (srem_sh >= trial) begin
          srem_q <= srem_sh - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          srem_q <= srem_sh;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      B_PREP: begin
        iter_q <= '0;
        drem_q <= '0;
        if (root_q == '0) begin
          dq_q <= (mag == '0) ? '0 : DVD_W'(1) << SAT_EXP;
        end else begin
          dq_q <= (DVD_W'(mag) << DIV_SHIFT) + DVD_W'(root_q >> 1);
        end
      end
      B_DIV: begin
        iter_q <= iter_q + ITER_W'(1);
        dq_q   <= {dq_q[DVD_W-2:0], ge};
        drem_q <= ge ? ROOT_W'(drem_sh - {1'b0, root_q}) : ROOT_W'(drem_sh);
      end
      B_OUT: begin
        if (load) begin
          out_ch.divergence <= res;
          out_ch.frame_end  <= fe_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/tv_divergence_stencil_top.sv
// ----------------------------------------------------------------------------
// tv_divergence_stencil_top
// total-variation divergence of a raster image with two line stores
// ----------------------------------------------------------------------------
// Pixels arrive in raster order and the result for a pixel is released when
// the pixel below it arrives; on the last row results follow the incoming
// pixels directly, with frame_end on the last one. The front takes a pixel
// only while idle and, per pixel, steps through the line store read at the
// accepting edge, a second read state, a compute state, the queue writes (one
// write per queued result) and a return to idle, and waits in the queue writes
// while the queue is full. Each result then passes through the back engine:
// taking the job, the shared squarer, the bit-serial square root, a setup
// step, the bit-serial divider (skipped when the norm is zero) and the output
// register, waiting in the output state while the output is stalled. The
// engine works on one result at a time, so the sustained rate is set by it.
// A four-entry job queue lets the front run ahead. The line stores have no
// clearing pass after reset. Configuration writes are registered in cfg_q.
// ----------------------------------------------------------------------------
`include "tv_divergence_stencil_top_macros.svh"

module tv_divergence_stencil_top import tvd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tvd_pixel_if.sink            in_ch,
  tvd_result_if.source         out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t         cfg_q;
  logic         fifo_push, fifo_pop;
  job_t         push_job, pop_job;
  fifo_status_t fifo_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= WCFG_W'(4096);
      cfg_q.image_height <= ROW_W'(4096);
      cfg_q.epsilon      <= EPS_W'(655);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data_i[WCFG_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data_i[ROW_W-1:0];
        CFG_EPSILON:      cfg_q.epsilon      <= cfg_data_i[EPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tvd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_ch  (in_ch),
    .full_i (fifo_st.full),
    .push_o (fifo_push),
    .job_o  (push_job)
  );

  tvd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fifo_push),
    .data_i   (push_job),
    .pop_i    (fifo_pop),
    .data_o   (pop_job),
    .status_o (fifo_st)
  );

  tvd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .job_i   (pop_job),
    .empty_i (fifo_st.empty),
    .pop_o   (fifo_pop),
    .out_ch  (out_ch)
  );

  `TVD_ASSERT(a_fifo_no_overflow, !(fifo_push && fifo_st.full), "job queue overflow")
  `TVD_ASSERT(a_fifo_no_underflow, !(fifo_pop && fifo_st.empty), "job queue underflow")
  `TVD_ASSERT_NEXT(a_fifo_count_up, fifo_push && !fifo_pop, fifo_st.count == FIFO_CW'($past(fifo_st.count) + 1), "job queue count did not grow")

endmodule
